### src/abaef_pkg.sv
`default_nettype none

package abaef_pkg;

    localparam int SAMPLE_W = 12;
    localparam int VALUE_W  = 20;
    localparam int ALPHA_W  = 17;
    localparam int CH_SLOTS = 2;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'h08000;
    localparam logic [VALUE_W-1:0] VALUE_MAX   = 20'hFFFFF;

    localparam logic [2:0] MODE_REQUEST   = 3'd0;
    localparam logic [2:0] MODE_SAMPLE    = 3'd1;
    localparam logic [2:0] MODE_FETCH     = 3'd2;
    localparam logic [2:0] MODE_RESET_FLT = 3'd3;
    localparam logic [2:0] MODE_CANCEL    = 3'd4;

    typedef struct packed {
        logic [2:0]          mode;
        logic                channel;
        logic [SAMPLE_W-1:0] sample_value;
    } t_in_word;

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] filtered_value;
        logic               busy_res;
        logic               batch_done;
    } t_out_word;

endpackage

`default_nettype wire

### src/abaef_avg.sv
`default_nettype none

// average in q12.8: floor((sum << 8) / SAMPLES) by reciprocal multiply
module abaef_avg #(
    parameter int SUM_W   = 16,
    parameter int SAMPLES = 16
) (
    input  wire logic [SUM_W-1:0]                i_sum,
    output logic      [abaef_pkg::VALUE_W-1:0]   o_avg
);

    localparam int RS = $clog2(SAMPLES);
    localparam int DW = SUM_W + 8;
    localparam int SH = DW + RS;
    localparam int MW = DW + 1;
    localparam int PW = SUM_W + MW;
    localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);
    localparam logic [MW-1:0] MULT = RECIP[MW-1:0];

    logic [PW-1:0] w_prod;
    logic [PW-1:0] w_quot;

    assign w_prod = PW'(i_sum) * PW'(MULT);
    // the shift by 8 of the dividend is folded into the final shift
    assign w_quot = w_prod >> (SH - 8);

    always_comb begin
        if (|w_quot[PW-1:abaef_pkg::VALUE_W]) begin
            o_avg = abaef_pkg::VALUE_MAX;
        end else begin
            o_avg = w_quot[abaef_pkg::VALUE_W-1:0];
        end
    end

endmodule

`default_nettype wire

### src/abaef_blend.sv
`default_nettype none

// new = (a * avg + (1 - a) * prev) >> 16, a clamped to one
module abaef_blend (
    input  wire logic [abaef_pkg::ALPHA_W-1:0] i_alpha,
    input  wire logic [abaef_pkg::VALUE_W-1:0] i_avg,
    input  wire logic [abaef_pkg::VALUE_W-1:0] i_prev,
    output logic      [abaef_pkg::VALUE_W-1:0] o_value
);

    localparam int AW = abaef_pkg::ALPHA_W + abaef_pkg::VALUE_W + 1;

    logic [abaef_pkg::ALPHA_W-1:0] w_a;
    logic [abaef_pkg::ALPHA_W-1:0] w_b;
    logic [AW-1:0]                 w_acc;

    assign w_a = (i_alpha > abaef_pkg::ALPHA_ONE) ? abaef_pkg::ALPHA_ONE : i_alpha;
    assign w_b = abaef_pkg::ALPHA_ONE - w_a;
    assign w_acc = AW'(w_a) * AW'(i_avg) + AW'(w_b) * AW'(i_prev);
    // the weighted sum never exceeds the larger input, so 20 bits hold it
    assign o_value = w_acc[abaef_pkg::VALUE_W+15:16];

endmodule

`default_nettype wire

### src/adc_batch_average_ema_filter.sv
`default_nettype none

// batch averager with per-channel exponential smoothing
// input channel: i_in_valid / o_in_ready carry one command word (mode, channel,
// sample_value); each accepted word yields exactly one result word on
// o_out_valid / i_out_ready (ok, filtered_value, busy_res, batch_done)
// config channel: i_cfg_valid / o_cfg_ready writes filter_alpha (q1.16);
// always ready, write it only while no word is in flight
// a command is held in the input register, then its result word sits in the
// result register until it is taken
// throughput: one word per cycle while the receiver keeps up; the whole step
// is done by the single logic pass between input and result register, set by
// the fetch multiply-add and the publish reciprocal multiply
// when the receiver stalls, the result register holds its word and the input
// register still takes one more word, then o_in_ready drops until the
// result is taken
// reset: no batch active, no result pending, filters unseeded and zero,
// filter_alpha back to one half, both registers empty
module adc_batch_average_ema_filter #(
    parameter int CHANNELS    = 2,
    parameter int SAMPLES     = 16,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire abaef_pkg::t_in_word           i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output abaef_pkg::t_out_word               o_out_data,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [abaef_pkg::ALPHA_W-1:0] i_cfg_data
);

    localparam int SMP_W = (SAMPLE_BITS < abaef_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                               : abaef_pkg::SAMPLE_W;
    localparam int SUM_W = $clog2(SAMPLES * ((1 << SMP_W) - 1) + 1);
    localparam int CNT_W = $clog2(SAMPLES + 1);
    localparam int VW    = abaef_pkg::VALUE_W;

    logic                          r_in_vld;
    abaef_pkg::t_in_word           r_in;
    logic                          r_out_vld;
    abaef_pkg::t_out_word          r_out;
    logic [abaef_pkg::ALPHA_W-1:0] r_alpha;

    logic                          r_active, n_active;
    logic                          r_act_ch, n_act_ch;
    logic [SUM_W-1:0]              r_sum, n_sum;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [abaef_pkg::CH_SLOTS-1:0] r_pend, n_pend;
    logic [abaef_pkg::CH_SLOTS-1:0] r_seed, n_seed;
    logic [VW-1:0]                 r_fv [abaef_pkg::CH_SLOTS];
    logic [VW-1:0]                 n_fv [abaef_pkg::CH_SLOTS];
    logic [VW-1:0]                 r_pub_avg [abaef_pkg::CH_SLOTS];

    logic                          w_adv;
    logic                          w_ch_ok;
    logic [SUM_W-1:0]              w_sum_add;
    logic                          w_last;
    logic [VW-1:0]                 w_avg;
    logic [VW-1:0]                 w_blend;
    logic [VW-1:0]                 w_fetch_val;
    logic                          w_pub_we;
    abaef_pkg::t_out_word          w_res;

    assign w_adv       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || w_adv;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    assign w_ch_ok   = (CHANNELS > 1) || !r_in.channel;
    assign w_sum_add = r_sum + SUM_W'(r_in.sample_value[SMP_W-1:0]);
    assign w_last    = (r_cnt == CNT_W'(SAMPLES - 1));

    abaef_avg #(
        .SUM_W   (SUM_W),
        .SAMPLES (SAMPLES)
    ) u_avg (
        .i_sum (w_sum_add),
        .o_avg (w_avg)
    );

    abaef_blend u_blend (
        .i_alpha (r_alpha),
        .i_avg   (r_pub_avg[r_in.channel]),
        .i_prev  (r_fv[r_in.channel]),
        .o_value (w_blend)
    );

    // first average after a filter reset seeds the channel
    assign w_fetch_val = r_seed[r_in.channel] ? w_blend : r_pub_avg[r_in.channel];

    always_comb begin
        n_active = r_active;
        n_act_ch = r_act_ch;
        n_sum    = r_sum;
        n_cnt    = r_cnt;
        n_pend   = r_pend;
        n_seed   = r_seed;
        n_fv     = r_fv;
        w_pub_we = 1'b0;
        w_res    = '0;
        if (w_adv) begin
            case (r_in.mode)
                abaef_pkg::MODE_REQUEST: begin
                    if (w_ch_ok && !r_active && !r_pend[r_in.channel]) begin
                        n_act_ch = r_in.channel;
                        n_active = 1'b1;
                        n_sum    = '0;
                        n_cnt    = '0;
                        w_res.ok = 1'b1;
                    end
                end
                abaef_pkg::MODE_SAMPLE: begin
                    if (r_active) begin
                        if (w_last) begin
                            w_pub_we         = 1'b1;
                            n_pend[r_act_ch] = 1'b1;
                            n_active         = 1'b0;
                            n_sum            = '0;
                            n_cnt            = '0;
                            w_res.batch_done = 1'b1;
                        end else begin
                            n_sum = w_sum_add;
                            n_cnt = r_cnt + CNT_W'(1);
                        end
                    end
                end
                abaef_pkg::MODE_FETCH: begin
                    if (w_ch_ok && r_pend[r_in.channel]) begin
                        n_pend[r_in.channel] = 1'b0;
                        n_seed[r_in.channel] = 1'b1;
                        n_fv[r_in.channel]   = w_fetch_val;
                        w_res.ok             = 1'b1;
                        w_res.filtered_value = w_fetch_val;
                    end
                end
                abaef_pkg::MODE_RESET_FLT: begin
                    if (w_ch_ok) begin
                        n_seed[r_in.channel] = 1'b0;
                        n_fv[r_in.channel]   = '0;
                    end
                end
                abaef_pkg::MODE_CANCEL: begin
                    n_active = 1'b0;
                    n_sum    = '0;
                    n_cnt    = '0;
                    n_pend   = '0;
                end
                default: begin
                end
            endcase
        end
        w_res.busy_res = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_alpha   <= abaef_pkg::ALPHA_RESET;
            r_active  <= 1'b0;
            r_act_ch  <= 1'b0;
            r_sum     <= '0;
            r_cnt     <= '0;
            r_pend    <= '0;
            r_seed    <= '0;
            for (int i = 0; i < abaef_pkg::CH_SLOTS; i++) begin
                r_fv[i] <= '0;
            end
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_alpha <= i_cfg_data;
            end
            r_active <= n_active;
            r_act_ch <= n_act_ch;
            r_sum    <= n_sum;
            r_cnt    <= n_cnt;
            r_pend   <= n_pend;
            r_seed   <= n_seed;
            r_fv     <= n_fv;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
        if (w_pub_we) begin
            r_pub_avg[r_act_ch] <= w_avg;
        end
    end

`ifndef SYNTHESIS
    a_done_sets_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_res.batch_done) |=> r_pend[$past(r_act_ch)])
        else $error("completed batch did not mark its channel pending");

    a_fetch_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in.mode == abaef_pkg::MODE_FETCH && w_res.ok)
        |=> !r_pend[$past(r_in.channel)] && r_seed[$past(r_in.channel)])
        else $error("fetch left channel pending or unseeded");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_cnt < CNT_W'(SAMPLES)))
        else $error("sample counter ran past batch length");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_cnt == '0 && r_sum == '0))
        else $error("idle batch holds sum or count");

    a_request_ok_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in.mode == abaef_pkg::MODE_REQUEST && w_res.ok)
        |-> !r_active && !r_pend[r_in.channel])
        else $error("request accepted while busy or pending");
`endif

endmodule

`default_nettype wire
